### hw/rtl/brpp_pkg.sv
// Shared types and constants for the bitmap row padding packer.
// No dependencies; every other file of the block imports this package.
package brpp_pkg;

  localparam int DATA_W         = 8;
  localparam int CFG_W          = 13;
  localparam int RES_W          = 7;
  localparam int RCNT_W         = 3;
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int OBUF_DEPTH     = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 13'd8;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 13'd1;

  typedef struct packed {
    logic [DATA_W-1:0] packed_byte;
    logic              image_end;
  } brpp_result_t;

endpackage

### hw/rtl/brpp_stream_if.sv
// Valid/ready stream interfaces for the bitmap row padding packer.
// Depends on brpp_pkg for the byte width.
interface brpp_in_if import brpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface brpp_out_if import brpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] packed_byte;
  logic              image_end;

  modport source (output valid, output packed_byte, output image_end, input ready);
  modport sink (input valid, input packed_byte, input image_end, output ready);
endinterface

### hw/rtl/brpp_step.sv
// Combinational step of the packer: merges one source byte into the residual
// and works out the next counters and up to two result bytes. Uses brpp_pkg.
module brpp_step import brpp_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic [CFG_W-1:0]  row_width,
  input  logic [CFG_W-1:0]  row_count,
  input  logic [DATA_W-1:0] source_byte,
  input  logic [CW-1:0]     column_position,
  input  logic [HW-1:0]     row_index,
  input  logic [RES_W-1:0]  residual_bits,
  input  logic [RCNT_W-1:0] residual_count,
  output logic [CW-1:0]     column_position_next,
  output logic [HW-1:0]     row_index_next,
  output logic [RES_W-1:0]  residual_bits_next,
  output logic [RCNT_W-1:0] residual_count_next,
  output logic [1:0]        push_cnt,
  output brpp_result_t      res0,
  output brpp_result_t      res1
);

  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int WW = ((CFG_W > WB) ? CFG_W : WB) + 1;
  localparam int HC = ((CFG_W > HB) ? CFG_W : HB) + 1;
  localparam int ACC_W = RES_W + DATA_W;

  logic [WW-1:0]     w_raw, w_eff, col_ext, diff;
  logic [HC-1:0]     h_raw, h_eff, row_ext;
  logic [3:0]        n;
  logic [DATA_W-1:0] mask8, low_bits, full_byte, flush_byte;
  logic [ACC_W-1:0]  acc;
  logic [3:0]        cnt;
  logic              full, row_done, last_row, image_done, flush;
  logic [RES_W-1:0]  res_a;
  logic [RCNT_W-1:0] rc_a;

  // Zero is taken as one, oversized values saturate to the maximum.
  always_comb begin
    w_raw = WW'(row_width);
    h_raw = HC'(row_count);
    if (w_raw == '0) begin
      w_eff = WW'(1);
    end else if (w_raw > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = HC'(1);
    end else if (h_raw > HC'(MAX_HEIGHT)) begin
      h_eff = HC'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  always_comb begin
    col_ext = WW'(column_position);
    row_ext = HC'(row_index);
    diff    = w_eff - col_ext;
    if (col_ext >= w_eff) begin
      n = 4'd0;
    end else if (diff < WW'(8)) begin
      n = diff[3:0];
    end else begin
      n = 4'd8;
    end

    // The valid pixels of a byte are its low n bits.
    mask8    = DATA_W'((9'h1 << n) - 9'h1);
    low_bits = source_byte & mask8;
    acc      = (ACC_W'(residual_bits) << n) | ACC_W'(low_bits);
    cnt      = 4'(residual_count) + n;
    full     = cnt[3];
    rc_a     = cnt[2:0];
    full_byte = DATA_W'(acc >> rc_a);
    if (full) begin
      res_a = RES_W'(acc & ((ACC_W'(1) << rc_a) - ACC_W'(1)));
    end else begin
      res_a = acc[RES_W-1:0];
    end

    row_done   = (col_ext + WW'(8)) >= w_eff;
    last_row   = (row_ext + HC'(1)) >= h_eff;
    image_done = row_done && last_row;
    flush      = image_done && (rc_a != '0);
    flush_byte = DATA_W'({res_a, 1'b0} << (3'd7 - rc_a));

    if (row_done) begin
      column_position_next = '0;
      row_index_next       = last_row ? '0 : HW'(row_ext + HC'(1));
    end else begin
      column_position_next = column_position + CW'(8);
      row_index_next       = row_index;
    end

    residual_bits_next  = flush ? '0 : res_a;
    residual_count_next = flush ? '0 : rc_a;

    push_cnt = {1'b0, full} + {1'b0, flush};
    if (full) begin
      res0.packed_byte = full_byte;
      res0.image_end   = image_done && !flush;
    end else begin
      res0.packed_byte = flush_byte;
      res0.image_end   = 1'b1;
    end
    res1.packed_byte = flush_byte;
    res1.image_end   = 1'b1;
  end

endmodule

### hw/rtl/brpp_obuf.sv
// Small result queue of the packer: takes up to two results a cycle and
// hands out one. Uses brpp_pkg for the result type and depth.
module brpp_obuf import brpp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   push_cnt,
  input  brpp_result_t push0,
  input  brpp_result_t push1,
  output logic         room,
  output logic         head_valid,
  output brpp_result_t head,
  input  logic         pop
);

  localparam int PW = $clog2(OBUF_DEPTH);

  brpp_result_t  mem [OBUF_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          do_pop;

  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;
  // Room for the worst case of two results from one transaction.
  assign room       = (count <= (PW+1)'(OBUF_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_cnt);
      rd_ptr <= rd_ptr + PW'(do_pop);
      count  <= count + (PW+1)'(push_cnt) - (PW+1)'(do_pop);
    end
  end

endmodule

### hw/rtl/bitmap_row_padding_packer.sv
// Top level of the bitmap row padding packer: input register, configuration
// registers, packing state, step logic and result queue. Uses brpp_pkg,
// brpp_in_if, brpp_out_if, brpp_step and brpp_obuf.
//
//   channel  direction  payload                      handshake
//   din      in         source_byte[7:0]             valid/ready
//   dout     out        packed_byte[7:0], image_end  valid/ready
//   cfg      in         cfg_index, cfg_data[12:0]    cfg_we, no wait
//
// A source byte is taken every cycle while the queue has room; its results
// are written into the queue when the byte fires and reach dout at the head
// of the queue. The queue of four entries sets the pace: a byte is merged
// only while two entries are free. Reset clears the counters, the residual,
// the queue and sets row_width to 8, row_count to 1. A stall on dout backs
// up through the queue and the input register to din.ready.
module bitmap_row_padding_packer import brpp_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  brpp_in_if.sink              din,
  brpp_out_if.source           dout
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [CFG_W-1:0]  row_width, row_count;
  logic              in_valid;
  logic [DATA_W-1:0] in_byte;
  logic [CW-1:0]     column_position, column_position_next;
  logic [HW-1:0]     row_index, row_index_next;
  logic [RES_W-1:0]  residual_bits, residual_bits_next;
  logic [RCNT_W-1:0] residual_count, residual_count_next;
  logic [1:0]        step_cnt, push_cnt;
  brpp_result_t      res0, res1, head;
  logic              room, head_valid, fire;

  assign fire      = in_valid && room;
  assign din.ready = !in_valid || fire;
  assign push_cnt  = fire ? step_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RST;
      row_count <= ROW_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_ROW_WIDTH: row_width <= cfg_data;
        CFG_IDX_ROW_COUNT: row_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (din.ready) begin
      in_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      in_byte <= din.source_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_index       <= '0;
      residual_bits   <= '0;
      residual_count  <= '0;
    end else if (fire) begin
      column_position <= column_position_next;
      row_index       <= row_index_next;
      residual_bits   <= residual_bits_next;
      residual_count  <= residual_count_next;
    end
  end

  brpp_step #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_step (
    .row_width           (row_width),
    .row_count           (row_count),
    .source_byte         (in_byte),
    .column_position     (column_position),
    .row_index           (row_index),
    .residual_bits       (residual_bits),
    .residual_count      (residual_count),
    .column_position_next(column_position_next),
    .row_index_next      (row_index_next),
    .residual_bits_next  (residual_bits_next),
    .residual_count_next (residual_count_next),
    .push_cnt            (step_cnt),
    .res0                (res0),
    .res1                (res1)
  );

  brpp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .head_valid(head_valid),
    .head      (head),
    .pop       (dout.ready)
  );

  assign dout.valid       = head_valid;
  assign dout.packed_byte = head.packed_byte;
  assign dout.image_end   = head.image_end;

endmodule
